### rtl/core/interrupt_priority_controller_unit_defines.svh
// Assertion macros used by the checker file of the interrupt priority controller.
// Depends on signals named clk and rst_n in the scope of each use.
`ifndef INTERRUPT_PRIORITY_CONTROLLER_UNIT_DEFINES_SVH
`define INTERRUPT_PRIORITY_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipc check failed");

// next-cycle implication, disabled during reset
`define IPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipc check failed");

`endif

### rtl/core/ipc_pkg.sv
// Types and constants of the interrupt priority controller.
// No dependencies; used by the top level and by ipc_prio.
package ipc_pkg;

  localparam int LINE_W = 8;
  localparam int LEVEL_W = 5;
  localparam int VEC_W = 10;
  localparam int DATA_W = 32;
  localparam int CFG_DATA_W = 40;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [2:0] {
    REQ_RAISE   = 3'd0,
    REQ_TIMER   = 3'd1,
    REQ_EVAL    = 3'd2,
    REQ_ACK     = 3'd3,
    REQ_READ    = 3'd4,
    REQ_WRITE   = 3'd5,
    REQ_RSVD6   = 3'd6,
    REQ_RSVD7   = 3'd7
  } req_type_t;

  localparam logic [1:0] REG_HALT     = 2'd0;
  localparam logic [1:0] REG_ERR_CTL  = 2'd1;
  localparam logic [1:0] REG_ERR_ADDR = 2'd2;
  localparam logic [1:0] REG_INT_VID  = 2'd3;

  localparam logic [1:0] BYTE_MASK   = 2'd0;
  localparam logic [1:0] BYTE_ORIGIN = 2'd1;
  localparam logic [1:0] BYTE_SELECT = 2'd2;
  localparam logic [1:0] BYTE_CLEAR  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_VEC_LO     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VEC_HI     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLK_VEC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLK_LEVEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HW_LEVEL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HW_MAX     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HALT_LEVEL = 3'd6;

  localparam logic [VEC_W-1:0]   CLK_VEC_RST    = 10'd192;
  localparam logic [LEVEL_W-1:0] CLK_LEVEL_RST  = 5'd22;
  localparam logic [LEVEL_W-1:0] HW_LEVEL_RST   = 5'd20;
  localparam logic [LEVEL_W-1:0] HW_MAX_RST     = 5'd23;
  localparam logic [LEVEL_W-1:0] HALT_LEVEL_RST = 5'd31;

  typedef struct packed {
    logic [LINE_W-1:0] hw_req;
    logic [LINE_W-1:0] line_mask;
    logic              timer_pend;
  } irq_state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] eval_level;
    logic [VEC_W-1:0]   ack_vector;
    logic               ack_err;
    logic               ack_clr_timer;
    logic [LINE_W-1:0]  ack_clr_lines;
  } prio_res_t;

  function automatic logic [LINE_W-1:0] line_bits(input int n);
    logic [LINE_W-1:0] bits;
    bits = '0;
    for (int i = 0; i < LINE_W; i++) begin
      bits[i] = (i < n);
    end
    return bits;
  endfunction

endpackage

### rtl/core/interrupt_priority_controller_unit.sv
// Top level of the interrupt priority controller: input stage, state, result register.
// Depends on ipc_pkg and ipc_prio.
//
// Channel | Direction | Handshake            | Beat
// in_     | input     | in_valid / in_ready   | one request (raise, timer, eval, ack, rd, wr)
// out_    | output    | out_valid / out_ready | one result: level, vector, read data, error
// cfg_    | input     | cfg_valid / cfg_ready | one config register write, index + data
//
// One beat per cycle in each direction while out_ready is high; an accepted beat passes
// through the input register into the result register, where it raises out_valid.
// State updates when a beat leaves the input register, so the next beat sees it.
// Reset (rst_n low, synchronous) clears both stages and the state and loads the config defaults.
// On an out_ stall the result holds; in_ready drops only when both stages are full
// and out_ready is low.
// cfg_ready is always high.
module interrupt_priority_controller_unit #(
  parameter int SOFT_LEVELS    = 15,
  parameter int HARDWARE_LINES = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2:0]                           in_req_type,
  input  logic [7:0]                           in_raise_lines,
  input  logic [4:0]                           in_cpu_level,
  input  logic [15:0]                          in_soft_requests,
  input  logic                                 in_halt_pin,
  input  logic [4:0]                           in_ack_level,
  input  logic [1:0]                           in_reg_index,
  input  logic [1:0]                           in_byte_offset,
  input  logic [31:0]                          in_write_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [4:0]                           out_level,
  output logic [9:0]                           out_vector,
  output logic [31:0]                          out_read_data,
  output logic                                 out_level_error,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ipc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ipc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam logic [ipc_pkg::LINE_W-1:0] LineBits = ipc_pkg::line_bits(HARDWARE_LINES);

  // config registers
  logic [ipc_pkg::CFG_DATA_W-1:0] vec_lo_r, vec_hi_r;
  logic [ipc_pkg::VEC_W-1:0]      clk_vec_r;
  logic [ipc_pkg::LEVEL_W-1:0]    clk_level_r, hw_level_r, hw_max_r, halt_level_r;

  // block state
  ipc_pkg::irq_state_t st_r, st_nxt;
  logic [31:0]         halt_code_r, halt_code_nxt;
  logic [1:0]          err_ctl_r, err_ctl_nxt;
  logic [7:0]          vid_origin_r, vid_origin_nxt;
  logic                vid_select_r, vid_select_nxt;

  // input stage
  logic                s1_vld_r;
  ipc_pkg::req_type_t  s1_type_r;
  logic [7:0]          s1_raise_r;
  logic [4:0]          s1_cpu_r;
  logic [15:0]         s1_soft_r;
  logic                s1_halt_r;
  logic [4:0]          s1_ack_r;
  logic [1:0]          s1_idx_r;
  logic [1:0]          s1_off_r;
  logic [31:0]         s1_wdata_r;

  // result stage
  logic                out_vld_r;
  logic [4:0]          out_level_r, out_level_nxt;
  logic [9:0]          out_vector_r, out_vector_nxt;
  logic [31:0]         out_rdata_r, out_rdata_nxt;
  logic                out_err_r, out_err_nxt;

  logic                out_free, s1_fire, in_fire;
  ipc_pkg::prio_res_t  prio;

  assign out_free = !out_vld_r || out_ready;
  assign s1_fire  = s1_vld_r && out_free;
  assign in_ready = !s1_vld_r || out_free;
  assign in_fire  = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign out_valid       = out_vld_r;
  assign out_level       = out_level_r;
  assign out_vector      = out_vector_r;
  assign out_read_data   = out_rdata_r;
  assign out_level_error = out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_lo_r     <= '0;
      vec_hi_r     <= '0;
      clk_vec_r    <= ipc_pkg::CLK_VEC_RST;
      clk_level_r  <= ipc_pkg::CLK_LEVEL_RST;
      hw_level_r   <= ipc_pkg::HW_LEVEL_RST;
      hw_max_r     <= ipc_pkg::HW_MAX_RST;
      halt_level_r <= ipc_pkg::HALT_LEVEL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ipc_pkg::CFG_VEC_LO:     vec_lo_r     <= cfg_data;
        ipc_pkg::CFG_VEC_HI:     vec_hi_r     <= cfg_data;
        ipc_pkg::CFG_CLK_VEC:    clk_vec_r    <= cfg_data[ipc_pkg::VEC_W-1:0];
        ipc_pkg::CFG_CLK_LEVEL:  clk_level_r  <= cfg_data[ipc_pkg::LEVEL_W-1:0];
        ipc_pkg::CFG_HW_LEVEL:   hw_level_r   <= cfg_data[ipc_pkg::LEVEL_W-1:0];
        ipc_pkg::CFG_HW_MAX:     hw_max_r     <= cfg_data[ipc_pkg::LEVEL_W-1:0];
        ipc_pkg::CFG_HALT_LEVEL: halt_level_r <= cfg_data[ipc_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_type_r  <= ipc_pkg::req_type_t'(in_req_type);
      s1_raise_r <= in_raise_lines;
      s1_cpu_r   <= in_cpu_level;
      s1_soft_r  <= in_soft_requests;
      s1_halt_r  <= in_halt_pin;
      s1_ack_r   <= in_ack_level;
      s1_idx_r   <= in_reg_index;
      s1_off_r   <= in_byte_offset;
      s1_wdata_r <= in_write_data;
    end
  end

  ipc_prio #(
    .SOFT_LEVELS    (SOFT_LEVELS),
    .HARDWARE_LINES (HARDWARE_LINES)
  ) u_prio (
    .st            (st_r),
    .cpu_level     (s1_cpu_r),
    .soft_requests (s1_soft_r),
    .halt_pin      (s1_halt_r),
    .ack_level     (s1_ack_r),
    .clock_level   (clk_level_r),
    .hw_level      (hw_level_r),
    .hw_max_level  (hw_max_r),
    .halt_level    (halt_level_r),
    .clock_vector  (clk_vec_r),
    .vectors_low   (vec_lo_r),
    .vectors_high  (vec_hi_r),
    .res           (prio)
  );

  always_comb begin
    st_nxt         = st_r;
    halt_code_nxt  = halt_code_r;
    err_ctl_nxt    = err_ctl_r;
    vid_origin_nxt = vid_origin_r;
    vid_select_nxt = vid_select_r;
    out_level_nxt  = '0;
    out_vector_nxt = '0;
    out_rdata_nxt  = '0;
    out_err_nxt    = 1'b0;
    unique case (s1_type_r)
      ipc_pkg::REQ_RAISE: begin
        st_nxt.hw_req = st_r.hw_req | (s1_raise_r & LineBits);
      end
      ipc_pkg::REQ_TIMER: begin
        st_nxt.timer_pend = 1'b1;
      end
      ipc_pkg::REQ_EVAL: begin
        out_level_nxt = prio.eval_level;
      end
      ipc_pkg::REQ_ACK: begin
        out_vector_nxt = prio.ack_vector;
        out_err_nxt    = prio.ack_err;
        st_nxt.hw_req  = st_r.hw_req & ~prio.ack_clr_lines;
        if (prio.ack_clr_timer) begin
          st_nxt.timer_pend = 1'b0;
        end
      end
      ipc_pkg::REQ_READ: begin
        unique case (s1_idx_r)
          ipc_pkg::REG_HALT:     out_rdata_nxt = halt_code_r;
          ipc_pkg::REG_ERR_CTL:  out_rdata_nxt = {30'd0, err_ctl_r};
          ipc_pkg::REG_ERR_ADDR: out_rdata_nxt = '0;
          default: out_rdata_nxt = {st_r.hw_req, 7'd0, vid_select_r, vid_origin_r,
                                    st_r.line_mask};
        endcase
      end
      ipc_pkg::REQ_WRITE: begin
        unique case (s1_idx_r)
          ipc_pkg::REG_HALT:     halt_code_nxt = s1_wdata_r;
          ipc_pkg::REG_ERR_CTL:  err_ctl_nxt = s1_wdata_r[1:0];
          ipc_pkg::REG_ERR_ADDR: ;
          default: begin
            unique case (s1_off_r)
              ipc_pkg::BYTE_MASK:   st_nxt.line_mask = s1_wdata_r[7:0];
              ipc_pkg::BYTE_ORIGIN: vid_origin_nxt = s1_wdata_r[7:0];
              ipc_pkg::BYTE_SELECT: vid_select_nxt = s1_wdata_r[0];
              default:              st_nxt.hw_req = st_r.hw_req & ~s1_wdata_r[7:0];
            endcase
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= '0;
      halt_code_r  <= '0;
      err_ctl_r    <= '0;
      vid_origin_r <= '0;
      vid_select_r <= 1'b0;
    end else if (s1_fire) begin
      st_r         <= st_nxt;
      halt_code_r  <= halt_code_nxt;
      err_ctl_r    <= err_ctl_nxt;
      vid_origin_r <= vid_origin_nxt;
      vid_select_r <= vid_select_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_level_r  <= out_level_nxt;
      out_vector_r <= out_vector_nxt;
      out_rdata_r  <= out_rdata_nxt;
      out_err_r    <= out_err_nxt;
    end
  end

endmodule

### rtl/core/ipc_prio.sv
// Priority logic: evaluate level selection and acknowledge selection of timer, level error or line.
// Depends on ipc_pkg.
module ipc_prio #(
  parameter int SOFT_LEVELS    = 15,
  parameter int HARDWARE_LINES = 8
) (
  input  ipc_pkg::irq_state_t                  st,
  input  logic [ipc_pkg::LEVEL_W-1:0]          cpu_level,
  input  logic [15:0]                          soft_requests,
  input  logic                                 halt_pin,
  input  logic [ipc_pkg::LEVEL_W-1:0]          ack_level,
  input  logic [ipc_pkg::LEVEL_W-1:0]          clock_level,
  input  logic [ipc_pkg::LEVEL_W-1:0]          hw_level,
  input  logic [ipc_pkg::LEVEL_W-1:0]          hw_max_level,
  input  logic [ipc_pkg::LEVEL_W-1:0]          halt_level,
  input  logic [ipc_pkg::VEC_W-1:0]            clock_vector,
  input  logic [ipc_pkg::CFG_DATA_W-1:0]       vectors_low,
  input  logic [ipc_pkg::CFG_DATA_W-1:0]       vectors_high,
  output ipc_pkg::prio_res_t                   res
);

  localparam logic [ipc_pkg::LINE_W-1:0] LineBits = ipc_pkg::line_bits(HARDWARE_LINES);

  logic [2*ipc_pkg::CFG_DATA_W-1:0] vec_tab;
  logic [ipc_pkg::LINE_W-1:0]       pend;
  logic [ipc_pkg::LEVEL_W-1:0]      soft_level;
  logic                             line_hit;
  logic [2:0]                       line_idx;

  assign vec_tab = {vectors_high, vectors_low};
  assign pend = st.hw_req & st.line_mask & LineBits;

  always_comb begin
    soft_level = '0;
    for (int i = 1; i < 16; i++) begin
      if (i <= SOFT_LEVELS && ipc_pkg::LEVEL_W'(i) > cpu_level && soft_requests[i]) begin
        soft_level = ipc_pkg::LEVEL_W'(i);
      end
    end
  end

  always_comb begin
    line_hit = 1'b0;
    line_idx = '0;
    for (int i = 0; i < HARDWARE_LINES; i++) begin
      if (pend[i]) begin
        line_hit = 1'b1;
        line_idx = 3'(i);
      end
    end
  end

  always_comb begin
    res = '0;
    if (halt_pin) begin
      res.eval_level = halt_level;
    end else if (cpu_level < clock_level && st.timer_pend) begin
      res.eval_level = clock_level;
    end else if (cpu_level < hw_level && (st.hw_req & st.line_mask) != '0) begin
      res.eval_level = hw_level;
    end else begin
      res.eval_level = soft_level;
    end

    if (ack_level == clock_level) begin
      res.ack_clr_timer = 1'b1;
      res.ack_vector = clock_vector;
    end else if (ack_level > hw_max_level) begin
      res.ack_err = 1'b1;
    end else if (line_hit) begin
      res.ack_clr_lines[line_idx] = 1'b1;
      res.ack_vector = vec_tab[{1'b0, line_idx, 3'd0} + {3'd0, line_idx, 1'b0} +:
                               ipc_pkg::VEC_W];
    end
  end

endmodule

### rtl/core/ipc_checker.sv
// Port-level checks of the interrupt priority controller, bound to its top level.
// Depends on interrupt_priority_controller_unit_defines.svh.
`include "interrupt_priority_controller_unit_defines.svh"

module ipc_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [4:0]                           out_level,
  input logic [9:0]                           out_vector,
  input logic [31:0]                          out_read_data,
  input logic                                 out_level_error
);

  `IPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `IPC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
                   $stable(out_level) && $stable(out_vector) && $stable(out_read_data))
  `IPC_ASSERT_NOW(a_err_alone, out_valid && out_level_error,
                  out_vector == 10'd0 && out_level == 5'd0 && out_read_data == 32'd0)
  `IPC_ASSERT_NOW(a_vec_alone, out_valid && out_vector != 10'd0,
                  out_level == 5'd0 && out_read_data == 32'd0 && !out_level_error)

endmodule

bind interrupt_priority_controller_unit ipc_checker u_ipc_checker (.*);
